>>> hw/rtl/budgeted_lru_eviction_table_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the budgeted LRU eviction table unit
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef BUDGETED_LRU_EVICTION_TABLE_UNIT_MACROS_SVH
`define BUDGETED_LRU_EVICTION_TABLE_UNIT_MACROS_SVH

// Property checked only outside reset.
`define BLET_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("blet assertion failed");

// Property checked on every edge, reset included.
`define BLET_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("blet assertion failed");

`endif

>>> hw/rtl/blet_pkg.sv
// ---------------------------------------------------------------------------
// Budgeted LRU eviction table package
// Types, constants and helpers shared by the table unit modules.
// ---------------------------------------------------------------------------
package blet_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int ID_W          = 16;
    localparam int SIZE_W        = 24;
    localparam int STAMP_W       = 32;
    localparam int TOT_W         = 30;
    localparam int CNT_OUT_W     = 6;
    localparam int MEM_ADDR_W    = 6;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [SIZE_W-1:0] BUDGET_RESET = 24'd131072;
    localparam logic [31:0]       MARGIN_UNITS = 32'd512;
    localparam logic [TOT_W-1:0]  TOTAL_MAX    = {TOT_W{1'b1}};

    // Register index, taken from address bit 2.
    localparam logic REG_BUDGET = 1'b0;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_DUMP  = 2'd2,
        KIND_TOUCH = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SIZE_W-1:0]  size;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
        t_entry                data;
    } t_mem_wr;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_SORT_RD0,
        ST_SORT_LD0,
        ST_SORT_PASS,
        ST_SORT_END,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_EVICT_SUM,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_APPEND,
        ST_RESULT
    } t_state;

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? TOTAL_MAX : s[TOT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/blet_intf.sv
// ---------------------------------------------------------------------------
// Budgeted LRU eviction table channel interfaces
// Request channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface blet_in_if
    import blet_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [ID_W-1:0]      object_id;
    logic [SIZE_W-1:0]    size_units;
    logic                 permanent;
    logic [STAMP_W-1:0]   stamp;

    modport source (output valid, kind, object_id, size_units, permanent, stamp,
                    input ready);
    modport sink   (input valid, kind, object_id, size_units, permanent, stamp,
                    output ready);
endinterface

interface blet_out_if
    import blet_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ID_W-1:0]      evicted_id;
    logic                 evicted_valid;
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] tracked_count;
    logic [TOT_W-1:0]     total_loaded;
    logic                 last;

    modport source (output valid, evicted_id, evicted_valid, status, tracked_count,
                    total_loaded, last, input ready);
    modport sink   (input valid, evicted_id, evicted_valid, status, tracked_count,
                    total_loaded, last, output ready);
endinterface

>>> hw/rtl/blet_mem.sv
// ---------------------------------------------------------------------------
// Entry memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module blet_mem
    import blet_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  t_mem_wr               i_wr,
    input  logic [MEM_ADDR_W-1:0] i_raddr,
    output t_entry                o_rdata
);
    localparam int AddrW = $clog2(DEPTH);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AddrW-1:0]] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr[AddrW-1:0]];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/blet_cfg.sv
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style write and read of the budget register.
// ---------------------------------------------------------------------------
module blet_cfg
    import blet_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [SIZE_W-1:0]     o_budget
);
    logic [SIZE_W-1:0] r_budget;
    logic              w_sel_budget;

    assign w_sel_budget = (paddr[2] == REG_BUDGET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RESET;
        end else if (psel && penable && pwrite && w_sel_budget) begin
            r_budget <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_budget) begin
            prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, r_budget};
        end
    end

    assign pready   = 1'b1;
    assign o_budget = r_budget;
endmodule

>>> hw/rtl/blet_ctrl.sv
// ---------------------------------------------------------------------------
// Table controller
// Sequencer that searches, compacts, sorts and evicts entries in the memory.
// ---------------------------------------------------------------------------
module blet_ctrl
    import blet_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SIZE_W-1:0]     i_budget,
    blet_in_if.sink               i_item,
    blet_out_if.source            o_res,
    output t_mem_wr               o_wr,
    output logic [MEM_ADDR_W-1:0] o_raddr,
    input  t_entry                i_rdata
);
    localparam int AddrW = $clog2(DEPTH);
    localparam int CntW  = $clog2(DEPTH + 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_state r_state, n_state;

    t_kind              r_kind;
    logic [ID_W-1:0]    r_id;
    logic [SIZE_W-1:0]  r_size;
    logic               r_perm_flag;
    logic [STAMP_W-1:0] r_stamp;

    logic [CntW-1:0]    r_cnt, n_cnt;
    logic [CntW-1:0]    r_top, n_top;
    logic [TOT_W-1:0]   r_total, n_total;
    logic [TOT_W-1:0]   r_perm, n_perm;
    logic signed [31:0] r_lose, n_lose;
    logic [TOT_W-1:0]   r_sum, n_sum;
    t_entry             r_carry, n_carry;
    logic               r_moved, n_moved;
    logic               r_first, n_first;
    logic [AddrW-1:0]   r_idx, n_idx;

    logic [ID_W-1:0]    r_res_id, n_res_id;
    logic               r_res_ev, n_res_ev;
    t_status            r_res_status, n_res_status;

    logic                 r_ovalid;
    logic [ID_W-1:0]      r_o_id, n_o_id;
    logic                 r_o_ev, n_o_ev;
    t_status              r_o_status, n_o_status;
    logic [CNT_OUT_W-1:0] r_o_cnt, n_o_cnt;
    logic [TOT_W-1:0]     r_o_total, n_o_total;
    logic                 r_o_last, n_o_last;
    logic                 w_load;

    logic               w_accept;
    logic               w_free;
    logic [TOT_W-1:0]   w_add_total;
    logic               w_over;
    logic               w_match;
    logic               w_idx_last;
    logic [CntW-1:0]    w_idx_next;
    logic               w_lose_pos;
    logic [CntW-1:0]    w_cnt_m1;
    logic [TOT_W-1:0]   w_rd_size;
    logic [TOT_W-1:0]   w_item_size;

    assign w_accept    = i_item.valid && i_item.ready;
    assign w_free      = !r_ovalid || o_res.ready;
    assign w_item_size = TOT_W'(r_size);
    assign w_rd_size   = TOT_W'(i_rdata.size);
    assign w_add_total = sat_add(r_total, w_item_size);
    assign w_over      = w_add_total > TOT_W'(i_budget);
    assign w_match     = (i_rdata.id == r_id);
    assign w_cnt_m1    = r_cnt - CntW'(1);
    assign w_idx_last  = (CntW'(r_idx) == w_cnt_m1);
    assign w_idx_next  = CntW'(r_idx) + CntW'(1);
    assign w_lose_pos  = (r_lose > 32'sd0);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (r_kind == KIND_ADD) begin
                    if (r_cnt == CntFull || r_perm_flag) begin
                        n_state = ST_RESULT;
                    end else if (!w_over) begin
                        n_state = ST_APPEND;
                    end else if (r_cnt == '0) begin
                        n_state = ST_EVICT_RD;
                    end else begin
                        n_state = ST_SORT_RD0;
                    end
                end else if (r_cnt == '0) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_FIND_RD;
                end
            end
            ST_FIND_RD:  n_state = ST_FIND_CHK;
            ST_FIND_CHK: begin
                if (w_match) begin
                    n_state = (r_kind == KIND_TOUCH) ? ST_RESULT : ST_SHIFT_RD;
                end else if (w_idx_last) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_FIND_RD;
                end
            end
            ST_SHIFT_RD: n_state = (w_idx_next < r_cnt) ? ST_SHIFT_WR : ST_RESULT;
            ST_SHIFT_WR: n_state = ST_SHIFT_RD;
            ST_SORT_RD0: n_state = ST_SORT_LD0;
            ST_SORT_LD0: begin
                n_state = (r_cnt == CntW'(1)) ? ST_EVICT_RD : ST_SORT_PASS;
            end
            ST_SORT_PASS: begin
                if (w_idx_last) begin
                    n_state = ST_SORT_END;
                end
            end
            ST_SORT_END:  n_state = r_moved ? ST_SORT_RD0 : ST_EVICT_RD;
            ST_EVICT_RD: begin
                n_state = (r_cnt != '0 && w_lose_pos) ? ST_EVICT_CHK : ST_EVICT_SUM;
            end
            ST_EVICT_CHK: n_state = ST_EVICT_RD;
            ST_EVICT_SUM: n_state = (r_top != r_cnt) ? ST_EMIT_RD : ST_APPEND;
            ST_EMIT_RD:   n_state = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (w_free) begin
                    n_state = (CntW'(r_idx) == r_cnt) ? ST_APPEND : ST_EMIT_RD;
                end
            end
            ST_APPEND:    n_state = ST_RESULT;
            ST_RESULT: begin
                if (w_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_cnt        = r_cnt;
        n_top        = r_top;
        n_total      = r_total;
        n_perm       = r_perm;
        n_lose       = r_lose;
        n_sum        = r_sum;
        n_carry      = r_carry;
        n_moved      = r_moved;
        n_first      = r_first;
        n_idx        = r_idx;
        n_res_id     = r_res_id;
        n_res_ev     = r_res_ev;
        n_res_status = r_res_status;
        n_o_id       = r_o_id;
        n_o_ev       = r_o_ev;
        n_o_status   = r_o_status;
        n_o_cnt      = r_o_cnt;
        n_o_total    = r_o_total;
        n_o_last     = r_o_last;
        w_load       = 1'b0;
        o_wr         = '0;
        o_raddr      = MEM_ADDR_W'(r_idx);

        case (r_state)
            ST_DECODE: begin
                n_res_id     = '0;
                n_res_ev     = 1'b0;
                n_res_status = STAT_DONE;
                n_idx        = '0;
                n_top        = r_cnt;
                n_sum        = '0;
                n_first      = 1'b1;
                if (r_kind == KIND_ADD) begin
                    if (r_cnt == CntFull) begin
                        n_res_status = STAT_FULL;
                    end else if (r_perm_flag) begin
                        n_total = w_add_total;
                        n_perm  = sat_add(r_perm, w_item_size);
                    end else begin
                        n_total = w_add_total;
                        n_lose  = $signed({2'b00, w_add_total}) + $signed(MARGIN_UNITS)
                                  - $signed({8'h00, i_budget});
                    end
                end else if (r_cnt == '0) begin
                    n_res_status = STAT_NOT_FOUND;
                end
            end
            ST_FIND_CHK: begin
                if (w_match) begin
                    if (r_kind == KIND_TOUCH) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = MEM_ADDR_W'(r_idx);
                        o_wr.data = '{id: i_rdata.id, size: i_rdata.size, stamp: r_stamp};
                    end else begin
                        n_total  = (w_rd_size > r_total) ? '0 : r_total - w_rd_size;
                        n_res_ev = (r_kind == KIND_DUMP);
                        n_res_id = (r_kind == KIND_DUMP) ? r_id : '0;
                    end
                end else if (w_idx_last) begin
                    n_res_status = STAT_NOT_FOUND;
                end else begin
                    n_idx = r_idx + AddrW'(1);
                end
            end
            ST_SHIFT_RD: begin
                o_raddr = MEM_ADDR_W'(w_idx_next);
                if (!(w_idx_next < r_cnt)) begin
                    n_cnt = w_cnt_m1;
                end
            end
            ST_SHIFT_WR: begin
                o_wr.en   = 1'b1;
                o_wr.addr = MEM_ADDR_W'(r_idx);
                o_wr.data = i_rdata;
                n_idx     = r_idx + AddrW'(1);
            end
            ST_SORT_RD0: begin
                o_raddr = '0;
            end
            ST_SORT_LD0: begin
                // The carried entry sinks toward the bottom; ties never pass.
                n_carry = i_rdata;
                n_moved = 1'b0;
                if (r_first) begin
                    n_sum = r_sum + w_rd_size;
                end
                n_idx   = AddrW'(1);
                o_raddr = MEM_ADDR_W'(1);
            end
            ST_SORT_PASS: begin
                o_wr.en   = 1'b1;
                o_wr.addr = MEM_ADDR_W'(r_idx - AddrW'(1));
                if (r_carry.stamp < i_rdata.stamp) begin
                    o_wr.data = i_rdata;
                    n_moved   = 1'b1;
                end else begin
                    o_wr.data = r_carry;
                    n_carry   = i_rdata;
                end
                if (r_first) begin
                    n_sum = r_sum + w_rd_size;
                end
                if (!w_idx_last) begin
                    n_idx   = r_idx + AddrW'(1);
                    o_raddr = MEM_ADDR_W'(w_idx_next);
                end
            end
            ST_SORT_END: begin
                o_wr.en   = 1'b1;
                o_wr.addr = MEM_ADDR_W'(w_cnt_m1);
                o_wr.data = r_carry;
                n_first   = 1'b0;
            end
            ST_EVICT_RD: begin
                o_raddr = MEM_ADDR_W'(w_cnt_m1);
            end
            ST_EVICT_CHK: begin
                n_lose = r_lose - $signed({8'h00, i_rdata.size});
                n_sum  = r_sum - w_rd_size;
                n_cnt  = w_cnt_m1;
            end
            ST_EVICT_SUM: begin
                n_total = sat_add(sat_add(r_perm, r_sum), w_item_size);
                n_idx   = AddrW'(r_top - CntW'(1));
            end
            ST_EMIT_RD: begin
                o_raddr = MEM_ADDR_W'(r_idx);
            end
            ST_EMIT_OUT: begin
                o_raddr = MEM_ADDR_W'(r_idx);
                if (w_free) begin
                    w_load     = 1'b1;
                    n_o_id     = i_rdata.id;
                    n_o_ev     = 1'b1;
                    n_o_status = STAT_DONE;
                    n_o_cnt    = CNT_OUT_W'(r_cnt + CntW'(1));
                    n_o_total  = r_total;
                    n_o_last   = 1'b0;
                    if (CntW'(r_idx) != r_cnt) begin
                        n_idx = r_idx - AddrW'(1);
                    end
                end
            end
            ST_APPEND: begin
                o_wr.en   = 1'b1;
                o_wr.addr = MEM_ADDR_W'(r_cnt);
                o_wr.data = '{id: r_id, size: r_size, stamp: r_stamp};
                n_cnt     = r_cnt + CntW'(1);
            end
            ST_RESULT: begin
                if (w_free) begin
                    w_load     = 1'b1;
                    n_o_id     = r_res_id;
                    n_o_ev     = r_res_ev;
                    n_o_status = r_res_status;
                    n_o_cnt    = CNT_OUT_W'(r_cnt);
                    n_o_total  = r_total;
                    n_o_last   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_total  <= '0;
            r_perm   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_perm  <= n_perm;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind      <= t_kind'(i_item.kind);
            r_id        <= i_item.object_id;
            r_size      <= i_item.size_units;
            r_perm_flag <= i_item.permanent;
            r_stamp     <= i_item.stamp;
        end
        r_top        <= n_top;
        r_lose       <= n_lose;
        r_sum        <= n_sum;
        r_carry      <= n_carry;
        r_moved      <= n_moved;
        r_first      <= n_first;
        r_idx        <= n_idx;
        r_res_id     <= n_res_id;
        r_res_ev     <= n_res_ev;
        r_res_status <= n_res_status;
        r_o_id       <= n_o_id;
        r_o_ev       <= n_o_ev;
        r_o_status   <= n_o_status;
        r_o_cnt      <= n_o_cnt;
        r_o_total    <= n_o_total;
        r_o_last     <= n_o_last;
    end

    assign i_item.ready        = (r_state == ST_IDLE);
    assign o_res.valid         = r_ovalid;
    assign o_res.evicted_id    = r_o_id;
    assign o_res.evicted_valid = r_o_ev;
    assign o_res.status        = r_o_status;
    assign o_res.tracked_count = r_o_cnt;
    assign o_res.total_loaded  = r_o_total;
    assign o_res.last          = r_o_last;
endmodule

>>> hw/rtl/budgeted_lru_eviction_table_unit.sv
// Permanent and full adds give only the final result; a plain add stores its entry first.
// Touch, remove and dump search the entries in order; remove and dump then compact the table.
// An add over budget runs a stable sort in the entry memory, at most DEPTH passes,
// then evicts the oldest entries and gives one result per evicted entry before the final one.
// One transaction at a time; the entry memory with one read and one write port paces each step.
// Reset is synchronous and clears count and totals at once; entries need no clearing pass.
// ---------------------------------------------------------------------------
// Budgeted LRU eviction table unit
// Tracks objects against a memory budget and evicts the oldest when over it.
// ---------------------------------------------------------------------------
module budgeted_lru_eviction_table_unit
    import blet_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    blet_in_if.sink               i_item,
    blet_out_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    logic [SIZE_W-1:0]     w_budget;
    t_mem_wr               w_wr;
    logic [MEM_ADDR_W-1:0] w_raddr;
    t_entry                w_rdata;

    blet_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_budget (w_budget)
    );

    blet_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    blet_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_budget (w_budget),
        .i_item   (i_item),
        .o_res    (o_res),
        .o_wr     (w_wr),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata)
    );
endmodule

>>> hw/rtl/blet_chk.sv
// ---------------------------------------------------------------------------
// Budgeted LRU eviction table checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "budgeted_lru_eviction_table_unit_macros.svh"

module blet_chk
    import blet_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input logic [ID_W-1:0]      i_evicted_id,
    input logic                 i_evicted_valid,
    input logic [1:0]           i_status,
    input logic [CNT_OUT_W-1:0] i_tracked_count,
    input logic [TOT_W-1:0]     i_total_loaded,
    input logic                 i_last
);
    localparam logic [CNT_OUT_W-1:0] CntFull = CNT_OUT_W'(DEPTH);

    // A stalled result stays valid and keeps its id, total and last flag.
    `BLET_ASSERT(a_out_hold, i_clk, i_rst_n,
        i_valid && !i_ready |=> i_valid && $stable(i_evicted_id) && $stable(i_total_loaded)
        && $stable(i_last))
    // Only evictions come before the final result of a transaction.
    `BLET_ASSERT(a_evict_first, i_clk, i_rst_n,
        i_valid && !i_last |-> i_evicted_valid && i_status == STAT_DONE)
    // A full table reports its full count and unloads nothing.
    `BLET_ASSERT(a_full_count, i_clk, i_rst_n,
        i_valid && i_status == STAT_FULL |-> i_tracked_count == CntFull && !i_evicted_valid)
    // The result register is empty after reset.
    `BLET_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_valid)
endmodule

bind budgeted_lru_eviction_table_unit blet_chk #(.DEPTH(DEPTH)) u_blet_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_evicted_id    (o_res.evicted_id),
    .i_evicted_valid (o_res.evicted_valid),
    .i_status        (o_res.status),
    .i_tracked_count (o_res.tracked_count),
    .i_total_loaded  (o_res.total_loaded),
    .i_last          (o_res.last)
);

>>> tb/budgeted_lru_eviction_table_unit_test.sv
// ---------------------------------------------------------------------------
// Budgeted LRU eviction table unit testbench
// Drives adds, removes, dumps and touches through the request channel, and
// predicts every result with a software copy of the table. The budget is
// reprogrammed over APB between phases, and source and sink idle at random.
// ---------------------------------------------------------------------------
module budgeted_lru_eviction_table_unit_test;
    import blet_pkg::*;

    localparam int  TABLE_DEPTH = 32;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam logic [SIZE_W-1:0] BUDGET_MAX = {SIZE_W{1'b1}};

    typedef struct {
        logic [ID_W-1:0]      evicted_id;
        logic                 evicted_valid;
        t_status              status;
        logic [CNT_OUT_W-1:0] tracked_count;
        logic [TOT_W-1:0]     total_loaded;
        logic                 last;
    } t_result;

    class eviction_table_scoreboard;
        logic [ID_W-1:0]    ids [TABLE_DEPTH];
        logic [SIZE_W-1:0]  sizes [TABLE_DEPTH];
        logic [STAMP_W-1:0] stamps [TABLE_DEPTH];
        int                 count;
        longint             total;
        longint             perm_total;
        longint             budget;
        t_result            expected_q[$];
        int                 failures;

        function new();
            count = 0;
            total = 0;
            perm_total = 0;
            budget = BUDGET_RESET;
            failures = 0;
        endfunction

        function longint sat(longint a, longint b);
            return (a + b > TOTAL_MAX) ? longint'(TOTAL_MAX) : a + b;
        endfunction

        function void push(logic [ID_W-1:0] id, logic v, t_status st);
            t_result r;
            r.evicted_id = id;
            r.evicted_valid = v;
            r.status = st;
            expected_q.push_back(r);
        endfunction

        // Stable insertion sort, largest stamp first.
        function void sort_by_stamp();
            logic [ID_W-1:0]    id;
            logic [SIZE_W-1:0]  sz;
            logic [STAMP_W-1:0] st;
            int j;
            for (int i = 1; i < count; i++) begin
                id = ids[i];
                sz = sizes[i];
                st = stamps[i];
                j = i;
                while (j > 0 && stamps[j-1] < st) begin
                    ids[j] = ids[j-1];
                    sizes[j] = sizes[j-1];
                    stamps[j] = stamps[j-1];
                    j--;
                end
                ids[j] = id;
                sizes[j] = sz;
                stamps[j] = st;
            end
        endfunction

        function void note_request(t_kind kind, logic [ID_W-1:0] id,
                                   logic [SIZE_W-1:0] size, logic perm,
                                   logic [STAMP_W-1:0] stamp);
            int     first;
            int     pos;
            longint lose;
            longint survivors;
            first = expected_q.size();
            if (kind == KIND_ADD) begin
                if (count >= TABLE_DEPTH) begin
                    push('0, 1'b0, STAT_FULL);
                end else if (perm) begin
                    total = sat(total, size);
                    perm_total = sat(perm_total, size);
                    push('0, 1'b0, STAT_DONE);
                end else begin
                    total = sat(total, size);
                    if (total > budget) begin
                        lose = total + MARGIN_UNITS - budget;
                        sort_by_stamp();
                        while (count > 0 && lose > 0) begin
                            push(ids[count-1], 1'b1, STAT_DONE);
                            lose -= sizes[count-1];
                            count--;
                        end
                        survivors = 0;
                        for (int i = 0; i < count; i++) survivors += sizes[i];
                        total = sat(sat(perm_total, survivors), size);
                    end
                    ids[count] = id;
                    sizes[count] = size;
                    stamps[count] = stamp;
                    count++;
                    push('0, 1'b0, STAT_DONE);
                end
            end else begin
                pos = -1;
                for (int i = 0; i < count; i++) begin
                    if (pos < 0 && ids[i] == id) pos = i;
                end
                if (pos < 0) begin
                    push('0, 1'b0, STAT_NOT_FOUND);
                end else if (kind == KIND_TOUCH) begin
                    stamps[pos] = stamp;
                    push('0, 1'b0, STAT_DONE);
                end else begin
                    total = (sizes[pos] > total) ? 0 : total - sizes[pos];
                    for (int i = pos; i + 1 < count; i++) begin
                        ids[i] = ids[i+1];
                        sizes[i] = sizes[i+1];
                        stamps[i] = stamps[i+1];
                    end
                    count--;
                    push((kind == KIND_DUMP) ? id : '0, kind == KIND_DUMP, STAT_DONE);
                end
            end
            for (int k = first; k < expected_q.size(); k++) begin
                expected_q[k].tracked_count = count;
                expected_q[k].total_loaded = total;
                expected_q[k].last = (k == expected_q.size() - 1);
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result with no transaction pending: id %0d", got.evicted_id);
                failures++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.evicted_id !== exp_r.evicted_id) begin
                $error("evicted_id: expected %0d, got %0d", exp_r.evicted_id, got.evicted_id);
                failures++;
            end
            if (got.evicted_valid !== exp_r.evicted_valid) begin
                $error("evicted_valid: expected %0d, got %0d",
                       exp_r.evicted_valid, got.evicted_valid);
                failures++;
            end
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                failures++;
            end
            if (got.tracked_count !== exp_r.tracked_count) begin
                $error("tracked_count: expected %0d, got %0d",
                       exp_r.tracked_count, got.tracked_count);
                failures++;
            end
            if (got.total_loaded !== exp_r.total_loaded) begin
                $error("total_loaded: expected %0d, got %0d",
                       exp_r.total_loaded, got.total_loaded);
                failures++;
            end
            if (got.last !== exp_r.last) begin
                $error("last: expected %0d, got %0d", exp_r.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    blet_in_if  req_if ();
    blet_out_if res_if ();

    budgeted_lru_eviction_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (req_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    eviction_table_scoreboard table_sb;
    int src_idle_pct;
    int sink_stall_pct;
    int sink_hold_cycles;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Sink side: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            res_if.ready <= 1'b0;
            sink_hold_cycles <= sink_hold_cycles - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                table_sb.note_request(t_kind'(req_if.kind), req_if.object_id,
                                      req_if.size_units, req_if.permanent, req_if.stamp);
            end
            if (res_if.valid && res_if.ready) begin
                got.evicted_id = res_if.evicted_id;
                got.evicted_valid = res_if.evicted_valid;
                got.status = t_status'(res_if.status);
                got.tracked_count = res_if.tracked_count;
                got.total_loaded = res_if.total_loaded;
                got.last = res_if.last;
                table_sb.check_result(got);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(t_kind kind, logic [ID_W-1:0] id, logic [SIZE_W-1:0] size,
                                logic perm, logic [STAMP_W-1:0] stamp);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind <= kind;
        req_if.object_id <= id;
        req_if.size_units <= size;
        req_if.permanent <= perm;
        req_if.stamp <= stamp;
        forever begin
            @(posedge i_clk);
            if (req_if.ready) break;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_until_drained();
        req_if.valid <= 1'b0;
        while (table_sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_budget(logic [SIZE_W-1:0] value);
        wait_until_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_BUDGET, 2'b00};
        pwdata <= {8'h00, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        table_sb.budget = value;
        @(negedge i_clk);
    endtask

    // Mostly well-formed traffic on a small id pool so that removes, dumps and
    // touches find their targets; occasional wide ids, sizes and stamps.
    task automatic send_random(int n);
        t_kind              kind;
        logic [ID_W-1:0]    id;
        logic [SIZE_W-1:0]  size;
        logic [STAMP_W-1:0] stamp;
        int                 pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            kind = (pick < 50) ? KIND_ADD : (pick < 65) ? KIND_STOP :
                   (pick < 80) ? KIND_DUMP : KIND_TOUCH;
            id = ($urandom_range(9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(15));
            case ($urandom_range(3))
                0: size = SIZE_W'($urandom);
                1: size = SIZE_W'($urandom_range(4095));
                default: size = SIZE_W'($urandom_range(32767));
            endcase
            stamp = ($urandom_range(2) == 0) ? $urandom : STAMP_W'($urandom_range(7));
            send_request(kind, id, size, $urandom_range(9) == 0, stamp);
        end
    endtask

    initial begin
        table_sb = new();
        cycle_count = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        sink_hold_cycles = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.kind = KIND_ADD;
        req_if.object_id = '0;
        req_if.size_units = '0;
        req_if.permanent = 1'b0;
        req_if.stamp = '0;
        res_if.ready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Operations on an empty table, then basic adds and an eviction.
        send_request(KIND_STOP, 16'h0001, '0, 1'b0, '0);
        send_request(KIND_DUMP, 16'hFFFF, '0, 1'b0, '0);
        send_request(KIND_TOUCH, 16'h0000, '0, 1'b0, 32'hFFFF_FFFF);
        send_request(KIND_ADD, 16'h0002, '0, 1'b1, '0);
        send_request(KIND_ADD, 16'h0005, BUDGET_MAX, 1'b0, '0);
        send_request(KIND_ADD, 16'h0006, 24'd100, 1'b0, 32'hFFFF_FFFF);
        send_request(KIND_ADD, 16'h0007, 24'd1000, 1'b0, 32'd10);
        send_request(KIND_ADD, 16'h0007, 24'd2000, 1'b0, 32'd10);
        send_request(KIND_ADD, 16'h0008, 24'd3000, 1'b0, 32'd10);
        send_request(KIND_TOUCH, 16'h0006, '0, 1'b0, 32'd0);
        send_request(KIND_STOP, 16'h0007, '0, 1'b0, '0);
        send_request(KIND_DUMP, 16'h0008, '0, 1'b0, '0);
        send_request(KIND_DUMP, 16'h0008, '0, 1'b0, '0);
        // Equal stamps: the later entry of a tie must go first.
        send_request(KIND_ADD, 16'h0009, 24'd60000, 1'b0, 32'd5);
        send_request(KIND_ADD, 16'h000A, 24'd60000, 1'b0, 32'd5);
        send_request(KIND_ADD, 16'h000B, 24'd60000, 1'b0, 32'd5);
        send_request(KIND_ADD, 16'h0003, 24'd10, 1'b1, '0);

        // Fill the table, then an add while full, permanent included.
        write_budget(BUDGET_MAX);
        for (int i = 0; i < 34; i++) begin
            send_request(KIND_ADD, ID_W'(16'h0100 + i), 24'd1, 1'b0, STAMP_W'(i));
        end
        send_request(KIND_ADD, 16'h0200, 24'd1, 1'b1, '0);

        write_budget('0);
        send_random(8);

        write_budget(24'd4096);
        src_idle_pct = 52;
        send_random(8);
        src_idle_pct = 0;
        sink_stall_pct = 52;
        send_random(8);
        src_idle_pct = 7;
        sink_stall_pct = 7;
        sink_hold_cycles = 400;
        send_random(8);
        src_idle_pct = 0;
        sink_stall_pct = 0;

        // Evict every entry with a zero budget, then saturate the total.
        write_budget('0);
        send_request(KIND_ADD, 16'h0300, 24'd1, 1'b0, '0);
        write_budget(BUDGET_RESET);
        for (int i = 0; i < 65; i++) begin
            send_request(KIND_ADD, ID_W'(i), BUDGET_MAX, 1'b1, '0);
        end
        sink_stall_pct = 52;
        send_random(8);

        wait_until_drained();
        repeat (200) @(negedge i_clk);
        if (table_sb.failures == 0 && table_sb.expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
